>>> rtl/ddrt_pkg.sv
// Package for the dense rank tree block: field structs, state codes, constants.
// No dependencies; every RTL file imports it.
`default_nettype none
package ddrt_pkg;
    localparam int MaxNodes  = 32;
    localparam int NodeW     = 5;
    localparam int ChanW     = 4;
    localparam int RatioAw   = 2 * NodeW + ChanW;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_SINK = 2'd1,
        FUNC_RUN  = 2'd2,
        FUNC_NOP  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_NODE_COUNT = 3'd0,
        CFG_DEF_RANK   = 3'd1,
        CFG_MIN_HOP    = 3'd2,
        CFG_MAX_RANK   = 3'd3,
        CFG_THRESHOLD  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  child_node;
        logic [4:0]  parent_node;
        logic [3:0]  channel;
        logic [7:0]  ratio;
        logic        is_sink;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  node_index;
        logic [15:0] rank;
        logic [4:0]  parent_index;
        logic        has_parent;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_PICK,
        ST_SUM,
        ST_AVG,
        ST_DIV,
        ST_RELAX,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic init_clr;    // clear scan/finished state for a new run
        logic init_step;   // initialize rank of node r_i
        logic scan_step;   // compare node r_i in minimum search
        logic pick;        // finish selected node, reset loop index
        logic sum_step;    // add one ratio byte (read pipeline)
        logic avg_take;    // form average and check threshold
        logic div_start;
        logic relax;       // apply candidate to node r_i
        logic idx_inc;     // advance node index
        logic emit;        // drive a result beat
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;    // node index is n-1
        logic n_zero;
        logic found;
        logic skip;        // node r_i finished (relax loop)
        logic sum_done;
        logic link_ok;
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

>>> rtl/dense_dijkstra_rank_tree.sv
// Top level of the dense rank tree block: controller plus datapath.
// Depends on ddrt_pkg, ddrt_ctrl, ddrt_data.
//
//  channel | ports                               | beat
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data     | write when i_cfg_we high
//  command | i_start, o_busy, i_item             | taken when i_start && !o_busy
//  result  | o_result_strobe, o_result           | one cycle per beat, no stall
//
// Loads and sink marks never raise busy. A compute initializes the n ranks,
// then per round runs a minimum scan over the n nodes, a pick step and a
// relax pass: finished nodes are skipped; a counted link sums its sixteen
// channel bytes on the single memory port, forms the average, runs the serial
// divider at one quotient bit per cycle and relaxes; an unusable link skips the divider.
// Then n result beats, one a cycle. Reset is synchronous, active low; the
// ratio memory is not cleared. The receiver cannot stall results.
`default_nettype none
module dense_dijkstra_rank_tree (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic                i_start,
    output logic                     o_busy,
    input  wire ddrt_pkg::t_in_item  i_item,
    output logic                     o_result_strobe,
    output ddrt_pkg::t_out_item      o_result
);
    import ddrt_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;
    logic    w_acc, w_go;

    assign w_acc = i_start && !o_busy;
    assign w_go  = w_acc && t_func'(i_item.func) == FUNC_RUN;

    ddrt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (w_go),
        .i_st   (w_st),
        .o_cmd  (w_cmd),
        .o_busy (o_busy)
    );

    ddrt_data u_data (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_load    (w_acc),
        .i_item    (i_item),
        .i_cmd     (w_cmd),
        .o_st      (w_st),
        .o_valid   (o_result_strobe),
        .o_item    (o_result)
    );
endmodule
`default_nettype wire

>>> rtl/ddrt_ctrl.sv
// Controller state machine for the rank tree: sequences init, search,
// relaxation and emission. Depends on ddrt_pkg.
`default_nettype none
module ddrt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire ddrt_pkg::t_status i_st,
    output ddrt_pkg::t_cmd        o_cmd,
    output logic                  o_busy
);
    import ddrt_pkg::*;

    t_state r_state, n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_go) n_state = i_st.n_zero ? ST_IDLE : ST_INIT;
            ST_INIT:  if (i_st.idx_last) n_state = ST_SCAN;
            ST_SCAN:  if (i_st.idx_last) n_state = ST_PICK;
            ST_PICK: begin
                n_state = i_st.found ? ST_SUM : ST_EMIT;
            end
            ST_SUM: begin
                if (i_st.skip) n_state = i_st.idx_last ? ST_SCAN : ST_SUM;
                else if (i_st.sum_done) n_state = ST_AVG;
            end
            ST_AVG:   n_state = i_st.link_ok ? ST_DIV : ST_RELAX;
            ST_DIV:   if (i_st.div_done) n_state = ST_RELAX;
            ST_RELAX: n_state = i_st.idx_last ? ST_SCAN : ST_SUM;
            ST_EMIT:  if (i_st.idx_last) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE:  o_cmd.init_clr = i_go;
            ST_INIT: begin
                o_cmd.init_step = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            ST_PICK:  o_cmd.pick = 1'b1;
            ST_SUM: begin
                // hold the sum once all sixteen bytes are in
                o_cmd.sum_step = !i_st.skip && !i_st.sum_done;
                o_cmd.idx_inc = i_st.skip;
            end
            ST_AVG: begin
                o_cmd.avg_take = 1'b1;
                o_cmd.div_start = i_st.link_ok;
            end
            ST_DIV:   ;
            ST_RELAX: begin
                o_cmd.relax = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            default:  ;
        endcase
    end

    // a scan can only end the search in the pick state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_st.idx_last) |=> (r_state == ST_PICK))
        else $error("scan did not end in pick");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_st.idx_last) |=> (r_state == ST_IDLE))
        else $error("emit did not return to idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.scan_step, o_cmd.relax, o_cmd.emit, o_cmd.init_step}))
        else $error("conflicting datapath commands");
endmodule
`default_nettype wire

>>> rtl/ddrt_data.sv
// Datapath for the rank tree: ratio memory, rank/parent tables, minimum
// search, channel sum, serial divider. Depends on ddrt_pkg.
`default_nettype none
module ddrt_data (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_load,
    input  wire ddrt_pkg::t_in_item i_item,
    input  wire ddrt_pkg::t_cmd    i_cmd,
    output ddrt_pkg::t_status      o_st,
    output logic                   o_valid,
    output ddrt_pkg::t_out_item    o_item
);
    import ddrt_pkg::*;

    // configuration
    logic [5:0]  r_node_count;
    logic [15:0] r_def_rank, r_min_hop, r_max_rank;
    logic [7:0]  r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 6'd32;
            r_def_rank   <= 16'hFFFF;
            r_min_hop    <= 16'd256;
            r_max_rank   <= 16'hFFFF;
            r_thresh     <= 8'd50;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NODE_COUNT: r_node_count <= i_cfg_data[5:0];
                CFG_DEF_RANK:   r_def_rank <= i_cfg_data;
                CFG_MIN_HOP:    r_min_hop <= i_cfg_data;
                CFG_MAX_RANK:   r_max_rank <= i_cfg_data;
                CFG_THRESHOLD:  r_thresh <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // nodes in use, clamped
    logic [5:0] w_n;
    assign w_n = (r_node_count > 6'(MaxNodes)) ? 6'(MaxNodes) : r_node_count;
    logic [4:0] w_n_last;
    assign w_n_last = 5'(w_n - 6'd1);

    // node loop index
    logic [4:0] r_i;
    assign o_st.idx_last = (r_i == w_n_last);
    assign o_st.n_zero = (w_n == 6'd0);

    // sink marks, finished marks, parent valid
    logic [MaxNodes-1:0] r_sink, r_fin, r_pvalid;
    logic [15:0] r_rank [MaxNodes];
    logic [4:0]  r_par  [MaxNodes];

    // minimum search registers
    logic [15:0] r_bound;
    logic [4:0]  r_u;
    logic        r_found;
    assign o_st.found = r_found;
    assign o_st.skip = r_fin[r_i];

    // ratio memory, one read port
    logic [7:0] r_mem [1 << RatioAw];
    logic [7:0] r_rd;
    logic [3:0] r_ch;        // channel issued
    logic       r_rd_v;      // read data valid
    logic [3:0] r_rd_cnt;    // bytes accumulated
    logic [11:0] r_sum;
    logic       r_sum_done;
    assign o_st.sum_done = r_sum_done;

    always_ff @(posedge i_clk) begin
        if (i_load && t_func'(i_item.func) == FUNC_LOAD) begin
            r_mem[{i_item.child_node, i_item.parent_node, i_item.channel}] <= i_item.ratio;
        end
        r_rd <= r_mem[{r_i, r_u, r_ch}];
    end

    // average and link check
    logic [7:0] w_avg;
    assign w_avg = r_sum[11:4];
    assign o_st.link_ok = (w_avg != 8'd0) && (w_avg > r_thresh);

    // serial divider: 200*min_hop (24 bits) / avg
    logic [23:0] r_quo;
    logic [8:0]  r_rem;
    logic [7:0]  r_div;
    logic [4:0]  r_dcnt;
    logic        r_dbusy;
    logic [15:0] r_cand;
    assign o_st.div_done = r_dbusy && (r_dcnt == 5'd0);
    logic [8:0] w_trial;
    assign w_trial = {r_rem[7:0], r_quo[23]};

    // candidate from finished quotient; saturate on a wide quotient or a carry
    logic [16:0] w_sum_rank;
    logic        w_sat;
    assign w_sum_rank = 17'(r_rank[r_u]) + 17'(r_quo[15:0]);
    assign w_sat = (r_quo[23:16] != 8'd0) || w_sum_rank[16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_sink <= '0;
            r_fin <= '0;
            r_pvalid <= '0;
            r_found <= 1'b0;
            r_dbusy <= 1'b0;
            r_rd_v <= 1'b0;
            r_sum_done <= 1'b0;
            r_ch <= '0;
            r_rd_cnt <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_load && t_func'(i_item.func) == FUNC_SINK) begin
                r_sink[i_item.child_node] <= i_item.is_sink;
            end
            // advance index
            if (i_cmd.idx_inc) begin
                r_i <= o_st.idx_last ? 5'd0 : r_i + 5'd1;
            end
            if (i_cmd.init_clr) begin
                r_i <= '0;
                r_fin <= '0;
                r_bound <= r_max_rank;
                r_found <= 1'b0;
            end
            if (i_cmd.init_step) begin
                r_rank[r_i] <= r_sink[r_i] ? r_min_hop : r_def_rank;
            end
            // minimum search, highest index wins on ties
            if (i_cmd.scan_step && !r_fin[r_i] && r_rank[r_i] <= r_bound) begin
                r_bound <= r_rank[r_i];
                r_u <= r_i;
                r_found <= 1'b1;
            end
            if (i_cmd.pick) begin
                if (r_found) r_fin[r_u] <= 1'b1;
                r_i <= '0;
                r_ch <= '0;
                r_rd_v <= 1'b0;
                r_rd_cnt <= '0;
                r_sum <= '0;
                r_sum_done <= 1'b0;
            end
            // channel sum: issue reads, accumulate the registered read data
            if (i_cmd.sum_step) begin
                if (r_ch != 4'd15 || !r_rd_v) begin
                    r_ch <= r_ch + 4'd1;
                end
                r_rd_v <= 1'b1;
                if (r_rd_v) begin
                    r_sum <= r_sum + 12'(r_rd);
                    r_rd_cnt <= r_rd_cnt + 4'd1;
                    if (r_rd_cnt == 4'd15) r_sum_done <= 1'b1;
                end
            end
            if (i_cmd.avg_take) begin
                r_sum_done <= 1'b0;
                r_ch <= '0;
                r_rd_v <= 1'b0;
                r_rd_cnt <= '0;
            end
            if (i_cmd.div_start) begin
                r_quo <= 24'(r_min_hop) * 24'd200;
                r_rem <= '0;
                r_div <= w_avg;
                r_dcnt <= 5'd24;
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt != 5'd0) begin
                if (w_trial >= {1'b0, r_div}) begin
                    r_rem <= w_trial - {1'b0, r_div};
                    r_quo <= {r_quo[22:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[22:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 5'd1;
            end else if (r_dbusy) begin
                r_dbusy <= 1'b0;
                r_cand <= w_sat ? 16'hFFFF : w_sum_rank[15:0];
            end
            if (i_cmd.avg_take && !o_st.link_ok) begin
                r_cand <= r_max_rank;
            end
            // relax node r_i through r_u
            if (i_cmd.relax) begin
                r_sum <= '0;
                if (r_rank[r_i] > r_cand) begin
                    r_rank[r_i] <= r_cand;
                    r_par[r_i] <= r_u;
                    r_pvalid[r_i] <= 1'b1;
                end
                if (o_st.idx_last) begin
                    r_bound <= r_max_rank;
                    r_found <= 1'b0;
                end
            end
            if (i_cmd.idx_inc && !i_cmd.relax && !i_cmd.scan_step && !i_cmd.init_step
                && !i_cmd.emit && o_st.idx_last) begin
                r_bound <= r_max_rank;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step && o_st.idx_last) begin
                r_i <= '0;
            end
            // result beat
            if (i_cmd.emit) begin
                o_valid <= 1'b1;
                o_item.node_index <= r_i;
                o_item.rank <= r_rank[r_i];
                o_item.parent_index <= r_pvalid[r_i] ? r_par[r_i] : 5'd0;
                o_item.has_parent <= r_pvalid[r_i];
                o_item.last <= o_st.idx_last;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_dbusy)
        else $error("divider did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick && r_found |=> r_fin[$past(r_u)])
        else $error("picked node not finished");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.has_parent |-> o_item.parent_index == 5'd0)
        else $error("parent shown without valid");
endmodule
`default_nettype wire

>>> tb/dense_dijkstra_rank_tree_test.sv
// Testbench for dense_dijkstra_rank_tree: directed table then random ratio loads,
// sink marks and tree computes, each checked against an in-bench rank tree predictor.
// Depends on ddrt_pkg and the dense_dijkstra_rank_tree RTL.
`timescale 1ns / 1ps
module dense_dijkstra_rank_tree_test;
    import ddrt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_start;
    logic        o_busy;
    t_in_item    i_item;
    logic        o_result_strobe;
    t_out_item   o_result;

    dense_dijkstra_rank_tree dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_start(i_start), .o_busy(o_busy), .i_item(i_item),
        .o_result_strobe(o_result_strobe), .o_result(o_result)
    );

    // predictor state
    logic [5:0]  cfg_nodes;
    logic [15:0] cfg_def_rank, cfg_min_hop, cfg_max_rank;
    logic [7:0]  cfg_thresh;
    logic [7:0]  ratio_mem [0:16383];
    bit          sink_mark [0:31];
    logic [15:0] rank_of [0:31];
    logic [4:0]  parent_of [0:31];
    bit          has_par [0:31];
    bit          done_mark [0:31];

    t_out_item   beats_due [$];
    int          err_count;

    // table of directed beats: item plus an optional typed-in expectation
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;
    t_row dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("dense_dijkstra_rank_tree_test: errors");
        $finish;
    end

    task automatic report(input string what);
        $display("MISMATCH %s at %0t", what, $realtime);
        err_count++;
    endtask

    // cost of the link from u to v, saturated
    function automatic logic [15:0] link_cand(input int u, input int v);
        int sum;
        int avg;
        longint tot;
        sum = 0;
        for (int c = 0; c < 16; c++) sum += ratio_mem[(v * 32 + u) * 16 + c];
        avg = sum / 16;
        if (avg != 0 && avg > cfg_thresh) begin
            tot = longint'(rank_of[u]) + (200 * int'(cfg_min_hop)) / avg;
            return tot > 65535 ? 16'hFFFF : 16'(tot);
        end
        return cfg_max_rank;
    endfunction

    // apply one accepted item to the predictor and queue expected beats
    task automatic predict_item(input t_in_item it);
        int n;
        int u;
        bit found;
        logic [15:0] bnd, cand;
        t_out_item r;
        case (t_func'(it.func))
            FUNC_LOAD: begin
                ratio_mem[(it.child_node * 32 + it.parent_node) * 16 + it.channel] = it.ratio;
            end
            FUNC_SINK: sink_mark[it.child_node] = it.is_sink;
            FUNC_RUN: begin
                n = cfg_nodes > 32 ? 32 : cfg_nodes;
                for (int i = 0; i < n; i++) begin
                    done_mark[i] = 0;
                    rank_of[i] = sink_mark[i] ? cfg_min_hop : cfg_def_rank;
                end
                forever begin
                    bnd = cfg_max_rank;
                    found = 0;
                    u = 0;
                    for (int i = 0; i < n; i++)
                        if (!done_mark[i] && rank_of[i] <= bnd) begin
                            bnd = rank_of[i];
                            u = i;
                            found = 1;
                        end
                    if (!found) break;
                    done_mark[u] = 1;
                    for (int i = 0; i < n; i++) begin
                        if (done_mark[i]) continue;
                        cand = link_cand(u, i);
                        if (rank_of[i] > cand) begin
                            rank_of[i] = cand;
                            parent_of[i] = 5'(u);
                            has_par[i] = 1;
                        end
                    end
                end
                for (int i = 0; i < n; i++) begin
                    r.node_index = 5'(i);
                    r.rank = rank_of[i];
                    r.parent_index = has_par[i] ? parent_of[i] : 5'd0;
                    r.has_parent = has_par[i];
                    r.last = (i == n - 1);
                    beats_due.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (beats_due.size() == 0) report("unexpected result beat");
            else begin
                t_out_item w;
                w = beats_due.pop_front();
                if (o_result.node_index !== w.node_index) report("node_index");
                if (o_result.rank !== w.rank) report("rank");
                if (o_result.parent_index !== w.parent_index) report("parent_index");
                if (o_result.has_parent !== w.has_parent) report("has_parent");
                if (o_result.last !== w.last) report("last");
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NODE_COUNT: cfg_nodes = val[5:0];
            CFG_DEF_RANK:   cfg_def_rank = val;
            CFG_MIN_HOP:    cfg_min_hop = val;
            CFG_MAX_RANK:   cfg_max_rank = val;
            CFG_THRESHOLD:  cfg_thresh = val[7:0];
            default: ;
        endcase
    endtask

    // wait for all beats, then let the block settle
    task automatic drain();
        while (beats_due.size() != 0 || o_busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // issue one item; hold start until accepted, then drop it for a cycle
    task automatic send_item(input t_in_item it);
        i_start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_busy);
        predict_item(it);
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    // random gap between bursts
    int burst_left;
    task automatic sender_pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        burst_left--;
    endtask

    function automatic t_in_item mk(input t_func f, input int c, input int p, input int ch,
                                    input int rt, input bit s);
        t_in_item it;
        it.func = f;
        it.child_node = 5'(c);
        it.parent_node = 5'(p);
        it.channel = 4'(ch);
        it.ratio = 8'(rt);
        it.is_sink = s;
        return it;
    endfunction

    // fill every ratio between distinct nodes 0..n-1 so no compute reads an
    // unwritten entry; a node's own entries are never read
    task automatic fill_links(input int n, input int mode);
        for (int c = 0; c < n; c++)
            for (int p = 0; p < n; p++)
                for (int ch = 0; ch < 16; ch++) begin
                    int v;
                    case (mode)
                        0: v = 0;
                        1: v = 255;
                        default: v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                                   : $urandom_range(40, 255);
                    endcase
                    if (c != p) begin
                        sender_pace();
                        send_item(mk(FUNC_LOAD, c, p, ch, v, $urandom_range(0, 1)));
                    end
                end
    endtask

    task automatic random_phase(input int n, input int items);
        fill_links(n, 2);
        for (int k = 0; k < items; k++) begin
            int r;
            r = $urandom_range(0, 9);
            sender_pace();
            if (r < 6) send_item(mk(FUNC_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                    $urandom_range(0, 15), $urandom_range(0, 255),
                                    $urandom_range(0, 1)));
            else if (r < 8) send_item(mk(FUNC_SINK, $urandom_range(0, 31), $urandom_range(0, 31),
                                         $urandom_range(0, 15), $urandom_range(0, 255),
                                         $urandom_range(0, 1)));
            else if (r < 9) send_item(mk(FUNC_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
                                        $urandom_range(0, 15), $urandom_range(0, 255),
                                        $urandom_range(0, 1)));
            else send_item(mk(FUNC_NOP, $urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1)));
        end
        send_item(mk(FUNC_RUN, 0, 0, 0, 0, 0));
        drain();
    endtask

    initial begin
        t_row row;
        err_count = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_start = 1'b0;
        i_item = '0;
        cfg_nodes = 6'd32;
        cfg_def_rank = 16'hFFFF;
        cfg_min_hop = 16'd256;
        cfg_max_rank = 16'hFFFF;
        cfg_thresh = 8'd50;
        for (int i = 0; i < 16384; i++) begin
            ratio_mem[i] = 8'd0;
        end
        for (int i = 0; i < 32; i++) begin
            sink_mark[i] = 0;
            has_par[i] = 0;
            parent_of[i] = 5'd0;
            rank_of[i] = 16'd0;
            done_mark[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one node after reset, no sink, all ratios zero
        write_reg(CFG_NODE_COUNT, 16'd1);
        for (int ch = 0; ch < 16; ch++) send_item(mk(FUNC_LOAD, 0, 0, ch, 0, 0));
        row.item = mk(FUNC_RUN, 0, 0, 0, 0, 0);
        row.typed = 1;
        row.want = '{node_index: 5'd0, rank: 16'hFFFF, parent_index: 5'd0,
                     has_parent: 1'b0, last: 1'b1};
        dir_rows.push_back(row);
        // sink at node 0 starts at min_hop_increase
        row.item = mk(FUNC_SINK, 0, 31, 15, 255, 1);
        row.typed = 0;
        dir_rows.push_back(row);
        row.item = mk(FUNC_RUN, 31, 31, 15, 255, 1);
        row.typed = 1;
        row.want = '{node_index: 5'd0, rank: 16'd256, parent_index: 5'd0,
                     has_parent: 1'b0, last: 1'b1};
        dir_rows.push_back(row);
        // unused func and out-of-use nodes do nothing
        row.item = mk(FUNC_NOP, 31, 31, 15, 255, 1);
        row.typed = 0;
        dir_rows.push_back(row);
        row.item = mk(FUNC_SINK, 31, 0, 0, 0, 0);
        dir_rows.push_back(row);
        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].item);
            if (dir_rows[k].typed) begin
                beats_due.pop_back();
                beats_due.push_back(dir_rows[k].want);
            end
        end
        drain();

        // node count zero emits nothing
        write_reg(CFG_NODE_COUNT, 16'd0);
        send_item(mk(FUNC_RUN, 0, 0, 0, 0, 0));
        drain();

        // two nodes: saturating full-ratio links, unusable links, then zero links
        write_reg(CFG_NODE_COUNT, 16'd2);
        write_reg(CFG_MIN_HOP, 16'hFFFF);
        write_reg(CFG_THRESHOLD, 16'd0);
        fill_links(2, 1);
        send_item(mk(FUNC_SINK, 1, 0, 0, 0, 1));
        send_item(mk(FUNC_RUN, 0, 0, 0, 0, 0));
        drain();
        write_reg(CFG_THRESHOLD, 16'd255);
        send_item(mk(FUNC_RUN, 0, 0, 0, 0, 0));
        drain();
        write_reg(CFG_THRESHOLD, 16'd0);
        write_reg(CFG_MIN_HOP, 16'd1);
        write_reg(CFG_MAX_RANK, 16'd0);
        write_reg(CFG_DEF_RANK, 16'd0);
        fill_links(2, 0);
        send_item(mk(FUNC_RUN, 0, 0, 0, 0, 0));
        drain();

        // random phases over two settings
        write_reg(CFG_THRESHOLD, 16'd50);
        write_reg(CFG_MAX_RANK, 16'hFFFF);
        write_reg(CFG_DEF_RANK, 16'hFFFF);
        write_reg(CFG_MIN_HOP, 16'd256);
        write_reg(CFG_NODE_COUNT, 16'd3);
        random_phase(3, 50);
        write_reg(CFG_NODE_COUNT, 16'd2);
        write_reg(CFG_MAX_RANK, 16'd40000);
        write_reg(CFG_DEF_RANK, 16'd30000);
        write_reg(CFG_MIN_HOP, 16'($urandom_range(1, 65535)));
        write_reg(CFG_THRESHOLD, 16'($urandom_range(0, 120)));
        random_phase(2, 40);

        if (err_count == 0) $display("dense_dijkstra_rank_tree_test: clean");
        else $display("dense_dijkstra_rank_tree_test: errors");
        $finish;
    end
endmodule
